// ===== rtl/tos_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tos_pkg;

   localparam int DEFAULT_STACK_DEPTH = 256;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 64;
   localparam int TYPE_W   = 4;
   localparam int DEPTH_W  = 9;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_PEEK   = 3'd2,
      ACT_SIZE   = 3'd3,
      ACT_VERIFY = 3'd4
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      CHK_PUSH_ONE = 2'd0,
      CHK_PUSH_TWO = 2'd1,
      CHK_POP_ONE  = 2'd2,
      CHK_POP_TWO  = 2'd3
   } check_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [TYPE_W-1:0] {
      TY_CHAR   = 4'd0,
      TY_SHORT  = 4'd1,
      TY_USHORT = 4'd2,
      TY_INT    = 4'd3,
      TY_UINT   = 4'd4,
      TY_STRING = 4'd5,
      TY_LONG   = 4'd6,
      TY_ULONG  = 4'd7
   } value_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [TYPE_W-1:0]  tag;
   } stack_entry_type;

   function automatic logic [VALUE_W-1:0] trim_value(input logic [VALUE_W-1:0] v,
                                                      input logic [TYPE_W-1:0]  t);
      logic [VALUE_W-1:0] r;
      r = '0;
      case (value_kind_type'(t))
         TY_CHAR: r = {56'd0, v[7:0]};
         TY_SHORT, TY_USHORT: r = {48'd0, v[15:0]};
         TY_INT, TY_UINT, TY_STRING: r = {32'd0, v[31:0]};
         TY_LONG, TY_ULONG: r = v;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tos_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tos_req_if;
   import tos_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  push_value;
   logic [TYPE_W-1:0]   push_type;
   logic [DEPTH_W-1:0]  peek_depth;
   logic [KIND_W-1:0]   check_kind;

   modport source (output valid, action, push_value, push_type, peek_depth, check_kind,
                   input ready);
   modport sink (input valid, action, push_value, push_type, peek_depth, check_kind,
                 output ready);
endinterface

interface tos_rsp_if;
   import tos_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  entry_value;
   logic [TYPE_W-1:0]   entry_type;
   logic [COUNT_W-1:0]  entry_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, entry_value, entry_type, entry_count, status,
                   input ready);
   modport sink (input valid, entry_value, entry_type, entry_count, status,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/tos_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tos_mem #(
   parameter int DEPTH = tos_pkg::DEFAULT_STACK_DEPTH,
   parameter int AW    = $clog2(tos_pkg::DEFAULT_STACK_DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire tos_pkg::stack_entry_type wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output tos_pkg::stack_entry_type      rd_data
);
   import tos_pkg::*;

   stack_entry_type mem [DEPTH];
   stack_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/typed_operand_stack_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake      payload
// req_chan  in         valid/ready    action, push_value, push_type, peek_depth, check_kind
// rsp_chan  out        valid/ready    entry_value, entry_type, entry_count, status
//
// pop and successful peek pass through the stack ram read register, then the output register.
// push, size, verify and failed pop/peek are written straight into the output register.
// one transaction in flight; a new one is taken as the output register drains.
// reset clears the count and the output valid; ram contents are not cleared.
// a stalled response holds its register and blocks new requests.
module typed_operand_stack_top #(
   parameter int STACK_DEPTH = tos_pkg::DEFAULT_STACK_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   tos_req_if.sink  req_chan,
   tos_rsp_if.source rsp_chan
);
   import tos_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int WW = ((CW > DEPTH_W) ? CW : DEPTH_W) + 1;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;

   logic                out_valid_ff;
   logic [VALUE_W-1:0]  out_value_ff;
   logic [TYPE_W-1:0]   out_type_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   status_type          out_status_ff;

   logic [WW-1:0] count_w, depth_w, limit_w;
   logic          accept, need_read, wr_en, rd_en;
   logic [AW-1:0] rd_addr, wr_addr;
   status_type    item_status;
   stack_entry_type wr_data, rd_data;

   assign count_w = WW'(count_ff);
   assign depth_w = WW'(req_chan.peek_depth);
   assign limit_w = WW'(STACK_DEPTH);

   assign req_chan.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   // decode of the incoming transaction
   always_comb begin
      item_status = STAT_OK;
      need_read   = 1'b0;
      wr_en       = 1'b0;
      rd_addr     = '0;
      count_in    = count_ff;
      unique case (action_type'(req_chan.action))
         ACT_PUSH: begin
            if (count_w == limit_w) begin
               item_status = STAT_FULL;
            end else begin
               wr_en    = accept;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP: begin
            if (count_w == '0) begin
               item_status = STAT_EMPTY;
            end else begin
               need_read = 1'b1;
               rd_addr   = AW'(count_ff - 1'b1);
               count_in  = count_ff - 1'b1;
            end
         end
         ACT_PEEK: begin
            if (depth_w == '0 || depth_w > count_w) begin
               item_status = STAT_EMPTY;
            end else begin
               need_read = 1'b1;
               rd_addr   = AW'(count_w - depth_w);
            end
         end
         ACT_VERIFY: begin
            case (check_kind_type'(req_chan.check_kind))
               CHK_PUSH_ONE: if (count_w + WW'(1) > limit_w) item_status = STAT_FULL;
               CHK_PUSH_TWO: if (count_w + WW'(2) > limit_w) item_status = STAT_FULL;
               CHK_POP_ONE:  if (count_w < WW'(1)) item_status = STAT_EMPTY;
               CHK_POP_TWO:  if (count_w < WW'(2)) item_status = STAT_EMPTY;
               default: item_status = STAT_OK;
            endcase
         end
         default: item_status = STAT_OK;
      endcase
   end

   assign rd_en   = accept && need_read;
   assign wr_addr = AW'(count_ff);
   assign wr_data = '{value: trim_value(req_chan.push_value, req_chan.push_type),
                      tag: req_chan.push_type};

   tos_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (rd_en) state_in = ST_READ;
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff <= count_in;
         end
         if (state_ff == ST_READ) begin
            out_valid_ff <= 1'b1;
         end else if (accept && !need_read) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         out_value_ff  <= rd_data.value;
         out_type_ff   <= rd_data.tag;
         out_count_ff  <= COUNT_W'(count_ff);
         out_status_ff <= STAT_OK;
      end else if (accept && !need_read) begin
         out_value_ff  <= '0;
         out_type_ff   <= '0;
         out_count_ff  <= COUNT_W'(count_in);
         out_status_ff <= item_status;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.entry_value = out_value_ff;
   assign rsp_chan.entry_type  = out_type_ff;
   assign rsp_chan.entry_count = out_count_ff;
   assign rsp_chan.status      = out_status_ff;

   // the ram read slot never overlaps a pending response
   a_read_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !out_valid_ff)
      else $error("ram read while a response is pending");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> out_valid_ff)
      else $error("ram read did not produce a response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_w <= limit_w)
      else $error("stack count beyond depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not advance the count");

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !accept)
      else $error("transaction accepted during ram read");

endmodule

`default_nettype wire

// ===== verif/tb_typed_operand_stack_top.sv =====
`timescale 1ns / 1ps

module tb_typed_operand_stack_top;
   import tos_pkg::*;

   localparam int STACK_SIZE   = DEFAULT_STACK_DEPTH;
   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 20;

   localparam logic [ACTION_W-1:0] ACT_RSVD_FIRST   = ACT_VERIFY + 1;
   localparam logic [ACTION_W-1:0] ACT_RSVD_LAST    = '1;
   localparam logic [TYPE_W-1:0]   TYPE_UNSIZED_MAX = '1;
   localparam logic [VALUE_W-1:0]  ALL_ONES         = '1;

   typedef enum int {
      WALK_FILL,
      WALK_MIX,
      WALK_DRAIN
   } walk_mode_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VALUE_W-1:0]  value;
      logic [TYPE_W-1:0]   vtype;
      logic [DEPTH_W-1:0]  depth;
      logic [KIND_W-1:0]   kind;
   } stack_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [TYPE_W-1:0]   vtype;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } stack_rsp_type;

   typedef struct {
      stack_req_type req;
      logic          typed;
      stack_rsp_type rsp;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset;

   tos_req_if req_bus ();
   tos_rsp_if rsp_bus ();

   typed_operand_stack_top #(
      .STACK_DEPTH(STACK_SIZE)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the stack
   logic [VALUE_W-1:0] shadow_value [STACK_SIZE];
   logic [TYPE_W-1:0]  shadow_type  [STACK_SIZE];
   int                 shadow_count = 0;

   stack_rsp_type pending_rsp_q [$];
   probe_row_type probe_rows [$];
   int            error_count = 0;
   int            sent_count  = 0;
   int            idle_cycles = 0;

   function automatic logic [VALUE_W-1:0] width_trim(input logic [VALUE_W-1:0] raw,
                                                      input logic [TYPE_W-1:0]  vtype);
      logic [VALUE_W-1:0] kept;
      kept = '0;
      case (vtype)
         TY_CHAR: kept = {{(VALUE_W-8){1'b0}}, raw[7:0]};
         TY_SHORT, TY_USHORT: kept = {{(VALUE_W-16){1'b0}}, raw[15:0]};
         TY_INT, TY_UINT, TY_STRING: kept = {{(VALUE_W-32){1'b0}}, raw[31:0]};
         TY_LONG, TY_ULONG: kept = raw;
         default: kept = '0;
      endcase
      return kept;
   endfunction

   function automatic stack_rsp_type apply_stack_op(input stack_req_type r);
      stack_rsp_type o;
      int            d;
      o = '0;
      o.status = STAT_OK;
      d = int'(r.depth);
      case (r.action)
         ACT_PUSH: begin
            if (shadow_count >= STACK_SIZE) begin
               o.status = STAT_FULL;
            end else begin
               shadow_value[shadow_count] = width_trim(r.value, r.vtype);
               shadow_type[shadow_count]  = r.vtype;
               shadow_count++;
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               shadow_count--;
               o.value = shadow_value[shadow_count];
               o.vtype = shadow_type[shadow_count];
            end
         end
         ACT_PEEK: begin
            if (d == 0 || d > shadow_count) begin
               o.status = STAT_EMPTY;
            end else begin
               o.value = shadow_value[shadow_count - d];
               o.vtype = shadow_type[shadow_count - d];
            end
         end
         ACT_VERIFY: begin
            case (r.kind)
               CHK_PUSH_ONE: if (shadow_count + 1 > STACK_SIZE) o.status = STAT_FULL;
               CHK_PUSH_TWO: if (shadow_count + 2 > STACK_SIZE) o.status = STAT_FULL;
               CHK_POP_ONE: if (shadow_count < 1) o.status = STAT_EMPTY;
               default: if (shadow_count < 2) o.status = STAT_EMPTY;
            endcase
         end
         default: ;
      endcase
      o.count = COUNT_W'(shadow_count);
      return o;
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input int w_push, input int w_pop,
                                                       input int w_peek, input int w_size,
                                                       input int w_verify);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < w_push) return ACT_PUSH;
      roll -= w_push;
      if (roll < w_pop) return ACT_POP;
      roll -= w_pop;
      if (roll < w_peek) return ACT_PEEK;
      roll -= w_peek;
      if (roll < w_size) return ACT_SIZE;
      roll -= w_size;
      if (roll < w_verify) return ACT_VERIFY;
      return ACTION_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
   endfunction

   task automatic add_row(input logic [ACTION_W-1:0] action, input logic [VALUE_W-1:0] value,
                          input logic [TYPE_W-1:0] vtype, input logic [DEPTH_W-1:0] depth,
                          input logic [KIND_W-1:0] kind, input logic typed,
                          input logic [VALUE_W-1:0] e_value, input logic [TYPE_W-1:0] e_type,
                          input int e_count, input logic [STATUS_W-1:0] e_status);
      probe_row_type row;
      row.req   = '{action, value, vtype, depth, kind};
      row.typed = typed;
      row.rsp   = '{e_value, e_type, COUNT_W'(e_count), e_status};
      probe_rows.push_back(row);
   endtask

   task automatic send_request(input stack_req_type r, input logic typed,
                               input stack_rsp_type fixed);
      int            gap;
      stack_rsp_type predicted;
      // every fourth block of 100 transactions goes back to back
      gap = ((sent_count / 100) % 4 == 3) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= r.action;
      req_bus.push_value <= r.value;
      req_bus.push_type  <= r.vtype;
      req_bus.peek_depth <= r.depth;
      req_bus.check_kind <= r.kind;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // state must advance even when the row carries a hand-written expectation
      predicted = apply_stack_op(r);
      pending_rsp_q.push_back(typed ? fixed : predicted);
      sent_count++;
   endtask

   // response side: random backpressure and scoreboard
   initial begin : rsp_side
      stack_rsp_type want;
      int            stall;
      int            rsp_seen;
      rsp_seen = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = ((rsp_seen / 80) % 4 == 1) ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         rsp_seen++;
         if (pending_rsp_q.size() == 0) begin
            $error("response transaction with nothing pending");
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_bus.entry_value !== want.value) begin
               $error("entry_value: expected %h, got %h", want.value, rsp_bus.entry_value);
               error_count++;
            end
            if (rsp_bus.entry_type !== want.vtype) begin
               $error("entry_type: expected %0d, got %0d", want.vtype, rsp_bus.entry_type);
               error_count++;
            end
            if (rsp_bus.entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_bus.entry_count);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : req_side
      stack_req_type r;
      probe_row_type row;
      walk_mode_type walk_mode;
      int            phase_idx;
      int            mode_left;
      logic          reached_end;
      int            roll;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_SIZE;
      req_bus.push_value <= '0;
      req_bus.push_type  <= TY_CHAR;
      req_bus.peek_depth <= '0;
      req_bus.check_kind <= CHK_PUSH_ONE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty stack corners
      add_row(ACT_POP, '0, TY_CHAR, 1, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 0, STAT_EMPTY);
      add_row(ACT_PEEK, '0, TY_CHAR, 1, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 0, STAT_EMPTY);
      add_row(ACT_SIZE, '0, TY_CHAR, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_VERIFY, '0, TY_CHAR, 0, CHK_POP_ONE, 1'b1, '0, TY_CHAR, 0, STAT_EMPTY);
      add_row(ACT_VERIFY, '0, TY_CHAR, 0, CHK_POP_TWO, 1'b1, '0, TY_CHAR, 0, STAT_EMPTY);
      add_row(ACT_VERIFY, '0, TY_CHAR, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_VERIFY, '0, TY_CHAR, 0, CHK_PUSH_TWO, 1'b1, '0, TY_CHAR, 0, STAT_OK);
      // one push of all ones per type, then an unsized one, then a zero char push
      add_row(ACT_PUSH, ALL_ONES, TY_CHAR, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 1, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_SHORT, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 2, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_USHORT, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 3, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_INT, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 4, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_UINT, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 5, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_STRING, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 6, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_LONG, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 7, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TY_ULONG, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 8, STAT_OK);
      add_row(ACT_PUSH, ALL_ONES, TYPE_UNSIZED_MAX, 0, CHK_PUSH_ONE, 1'b1,
              '0, TY_CHAR, 9, STAT_OK);
      add_row(ACT_PUSH, '0, TY_CHAR, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 10, STAT_OK);
      // bad depths, then good peeks, a verify, two pops and the reserved actions
      add_row(ACT_PEEK, '0, TY_CHAR, 0, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 10, STAT_EMPTY);
      add_row(ACT_PEEK, '0, TY_CHAR, '1, CHK_PUSH_ONE, 1'b1, '0, TY_CHAR, 10, STAT_EMPTY);
      add_row(ACT_PEEK, '0, TY_CHAR, 10, CHK_PUSH_ONE, 1'b0, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_PEEK, '0, TY_CHAR, 2, CHK_PUSH_ONE, 1'b0, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_VERIFY, '0, TY_CHAR, 0, CHK_POP_TWO, 1'b0, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_POP, '0, TY_CHAR, 0, CHK_PUSH_ONE, 1'b0, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_POP, '0, TY_CHAR, 0, CHK_PUSH_ONE, 1'b0, '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_RSVD_FIRST, ALL_ONES, TY_LONG, 1, CHK_POP_TWO, 1'b0,
              '0, TY_CHAR, 0, STAT_OK);
      add_row(ACT_RSVD_LAST, ALL_ONES, TY_LONG, 1, CHK_POP_TWO, 1'b0,
              '0, TY_CHAR, 0, STAT_OK);

      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         send_request(row.req, row.typed, row.rsp);
      end

      // random walk: fill to the top, wander, drain to empty, wander, repeat
      phase_idx   = 0;
      walk_mode   = WALK_FILL;
      mode_left   = $urandom_range(20, 40);
      reached_end = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (walk_mode == WALK_FILL && shadow_count == STACK_SIZE) reached_end = 1'b1;
         if (walk_mode == WALK_DRAIN && shadow_count == 0) reached_end = 1'b1;
         if (walk_mode == WALK_MIX || reached_end) mode_left--;
         if (mode_left <= 0) begin
            phase_idx++;
            reached_end = 1'b0;
            case (phase_idx % 4)
               0: walk_mode = WALK_FILL;
               2: walk_mode = WALK_DRAIN;
               default: walk_mode = WALK_MIX;
            endcase
            mode_left = (walk_mode == WALK_MIX) ? $urandom_range(100, 200)
                                                : $urandom_range(20, 40);
         end

         case (walk_mode)
            WALK_FILL: begin
               r.action = (shadow_count >= STACK_SIZE - 4) ? pick_action(45, 25, 10, 5, 13)
                                                           : pick_action(80, 4, 6, 2, 6);
            end
            WALK_DRAIN: begin
               r.action = (shadow_count <= 3) ? pick_action(30, 35, 15, 5, 13)
                                              : pick_action(4, 80, 6, 2, 6);
            end
            default: r.action = pick_action(30, 25, 20, 7, 13);
         endcase

         roll = $urandom_range(0, 7);
         if (roll == 0) r.value = '0;
         else if (roll == 1) r.value = ALL_ONES;
         else r.value = {$urandom(), $urandom()};

         if ($urandom_range(0, 3) == 0)
            r.vtype = TYPE_W'($urandom_range(TY_ULONG + 1, TYPE_UNSIZED_MAX));
         else
            r.vtype = TYPE_W'($urandom_range(TY_CHAR, TY_ULONG));

         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            r.depth = '0;
         end else if (roll == 1) begin
            r.depth = DEPTH_W'($urandom());
         end else if (roll == 2) begin
            r.depth = DEPTH_W'($urandom_range(shadow_count + 1, (1 << DEPTH_W) - 1));
         end else begin
            r.depth = (shadow_count > 0) ? DEPTH_W'($urandom_range(1, shadow_count)) : 1;
         end

         r.kind = KIND_W'($urandom());
         send_request(r, 1'b0, '0);
      end

      req_bus.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
